>>> rtl/sdpe_pkg.sv
package sdpe_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int ACC_BITS    = 30;
    localparam int ANG_BITS    = 30;
    localparam int PROD_BITS   = 2 * ACC_BITS;
    localparam int MAG_BITS    = 2 * ACC_BITS;
    localparam int YW_BITS     = 2 * ACC_BITS + 1;
    localparam int CW_BITS     = ANG_BITS + 3;
    localparam int PHASE_BITS  = 16;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [1:0] STATUS_ZERO_SUM = 2'd2;

    localparam logic [1:0] LAST_CHAN = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ref_i;
        logic signed [SAMPLE_BITS-1:0] ref_q;
        logic signed [SAMPLE_BITS-1:0] ch1_i;
        logic signed [SAMPLE_BITS-1:0] ch1_q;
        logic signed [SAMPLE_BITS-1:0] ch2_i;
        logic signed [SAMPLE_BITS-1:0] ch2_q;
        logic signed [SAMPLE_BITS-1:0] ch3_i;
        logic signed [SAMPLE_BITS-1:0] ch3_q;
        logic                          has_sample;
        logic                          last;
    } in_t;

    typedef struct packed {
        logic signed [PHASE_BITS-1:0] phase1;
        logic signed [PHASE_BITS-1:0] phase2;
        logic signed [PHASE_BITS-1:0] phase3;
        logic [1:0]                   status;
        logic [2:0]                   zero_sum_mask;
    } out_t;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_CHAN,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_ABS,
        ST_NORM,
        ST_CORDIC,
        ST_ROUND,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SI_SI,
        MUL_SQ_SQ,
        MUL_DI_SQ,
        MUL_DQ_SI
    } mul_op_t;

    typedef struct packed {
        logic       acc_en;
        logic       clear;
        logic [1:0] chan;
        mul_op_t    mul_op;
        logic       x_load;
        logic       x_add;
        logic       y_load;
        logic       y_sub;
        logic       abs_load;
        logic       norm;
        logic       cordic_init;
        logic       cordic_step;
        logic [4:0] step;
        logic       store_phase;
        logic       store_zero;
        logic       mark_zero;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic zero_sum;
        logic need_shift;
    } stat_t;

    // Arctangent of 2^-i in units of 2^-30 radian.
    function automatic logic [ANG_BITS-1:0] atan_val(input logic [4:0] idx);
        logic [ANG_BITS-1:0] v;
        unique case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000008;
            5'd28: v = 30'h00000004;
            5'd29: v = 30'h00000002;
            5'd30: v = 30'h00000001;
            5'd31: v = 30'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/sdpe_datapath.sv
module sdpe_datapath #(
    parameter int MAX_PAIRS       = 65536,
    parameter int PHASE_FRAC_BITS = 13
) (
    input  logic           clk,
    input  logic           rst_n,
    input  sdpe_pkg::in_t  in_data,
    input  sdpe_pkg::cmd_t cmd,
    output sdpe_pkg::stat_t stat,
    output sdpe_pkg::out_t out_data
);
    import sdpe_pkg::*;

    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int RND_SH = ANG_BITS - PHASE_FRAC_BITS - 1;
    localparam int ZR_W   = CW_BITS + 1;

    logic signed [ACC_BITS-1:0] sum_i_reg  [3];
    logic signed [ACC_BITS-1:0] sum_q_reg  [3];
    logic signed [ACC_BITS-1:0] diff_i_reg [3];
    logic signed [ACC_BITS-1:0] diff_q_reg [3];
    logic [CNT_W-1:0]           pair_count_reg;

    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic [MAG_BITS-1:0]         x_reg, x_next;
    logic signed [YW_BITS-1:0]   y_reg, y_next;
    logic [MAG_BITS-1:0]         ay_reg, ay_next;
    logic                        neg_reg, neg_next;
    logic signed [CW_BITS-1:0]   cx_reg, cx_next, cy_reg, cy_next, z_reg, z_next;
    logic signed [PHASE_BITS-1:0] phase_reg [3];
    logic [2:0]                  mask_reg;
    out_t                        out_reg;

    logic                        full;
    logic                        take;
    logic signed [SAMPLE_BITS-1:0] ch_i [3];
    logic signed [SAMPLE_BITS-1:0] ch_q [3];
    logic signed [ACC_BITS-1:0]  mul_a, mul_b;
    logic signed [CW_BITS-1:0]   cx_sh, cy_sh, atan_s;
    logic signed [ZR_W-1:0]      z_rnd, ph_full;
    logic signed [PHASE_BITS-1:0] ph_sat;
    logic [1:0]                  status_now;

    assign full = (pair_count_reg == CNT_W'(MAX_PAIRS));
    assign take = cmd.acc_en && in_data.has_sample && !full;

    assign ch_i[0] = in_data.ch1_i;
    assign ch_q[0] = in_data.ch1_q;
    assign ch_i[1] = in_data.ch2_i;
    assign ch_q[1] = in_data.ch2_q;
    assign ch_i[2] = in_data.ch3_i;
    assign ch_q[2] = in_data.ch3_q;

    // The accumulators for the three channels update side by side.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_i_reg[k]  <= '0;
                sum_q_reg[k]  <= '0;
                diff_i_reg[k] <= '0;
                diff_q_reg[k] <= '0;
            end
            pair_count_reg <= '0;
        end
        else if (cmd.clear)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_i_reg[k]  <= '0;
                sum_q_reg[k]  <= '0;
                diff_i_reg[k] <= '0;
                diff_q_reg[k] <= '0;
            end
            pair_count_reg <= '0;
        end
        else if (take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sum_i_reg[k]  <= sum_i_reg[k] + ACC_BITS'(in_data.ref_i)
                                 + ACC_BITS'(ch_i[k]);
                sum_q_reg[k]  <= sum_q_reg[k] + ACC_BITS'(in_data.ref_q)
                                 + ACC_BITS'(ch_q[k]);
                diff_i_reg[k] <= diff_i_reg[k] + ACC_BITS'(in_data.ref_i)
                                 - ACC_BITS'(ch_i[k]);
                diff_q_reg[k] <= diff_q_reg[k] + ACC_BITS'(in_data.ref_q)
                                 - ACC_BITS'(ch_q[k]);
            end
            pair_count_reg <= pair_count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        mul_a = sum_i_reg[cmd.chan];
        mul_b = sum_i_reg[cmd.chan];
        unique case (cmd.mul_op)
            MUL_SI_SI:
            begin
                mul_a = sum_i_reg[cmd.chan];
                mul_b = sum_i_reg[cmd.chan];
            end
            MUL_SQ_SQ:
            begin
                mul_a = sum_q_reg[cmd.chan];
                mul_b = sum_q_reg[cmd.chan];
            end
            MUL_DI_SQ:
            begin
                mul_a = diff_i_reg[cmd.chan];
                mul_b = sum_q_reg[cmd.chan];
            end
            MUL_DQ_SI:
            begin
                mul_a = diff_q_reg[cmd.chan];
                mul_b = sum_i_reg[cmd.chan];
            end
            default:
            begin
                mul_a = sum_i_reg[cmd.chan];
                mul_b = sum_i_reg[cmd.chan];
            end
        endcase
    end

    assign cx_sh  = cx_reg >>> cmd.step;
    assign cy_sh  = cy_reg >>> cmd.step;
    assign atan_s = $signed({3'b000, atan_val(cmd.step)});

    always_comb
    begin
        prod_next = (cmd.mul_op == MUL_NONE) ? prod_reg : mul_a * mul_b;
        x_next    = x_reg;
        y_next    = y_reg;
        ay_next   = ay_reg;
        neg_next  = neg_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        z_next    = z_reg;
        if (cmd.x_load)
            x_next = MAG_BITS'(prod_reg);
        if (cmd.x_add)
            x_next = x_reg + MAG_BITS'(prod_reg);
        if (cmd.y_load)
            y_next = YW_BITS'(prod_reg);
        if (cmd.y_sub)
            y_next = y_reg - YW_BITS'(prod_reg);
        if (cmd.abs_load)
        begin
            neg_next = y_reg[YW_BITS-1];
            ay_next  = y_reg[YW_BITS-1] ? MAG_BITS'(-y_reg) : MAG_BITS'(y_reg);
        end
        if (cmd.norm)
        begin
            x_next  = x_reg >> 1;
            ay_next = ay_reg >> 1;
        end
        if (cmd.cordic_init)
        begin
            cx_next = $signed({3'b000, x_reg[ANG_BITS-1:0]});
            cy_next = $signed({3'b000, ay_reg[ANG_BITS-1:0]});
            z_next  = '0;
        end
        if (cmd.cordic_step)
        begin
            if (cy_reg > 0)
            begin
                cx_next = cx_reg + cy_sh;
                cy_next = cy_reg - cx_sh;
                z_next  = z_reg + atan_s;
            end
            else
            begin
                cx_next = cx_reg - cy_sh;
                cy_next = cy_reg + cx_sh;
                z_next  = z_reg - atan_s;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ay_reg   <= ay_next;
        neg_reg  <= neg_next;
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
    end

    // Twice the angle, rounded half up, then signed and saturated.
    assign z_rnd   = (ZR_W'(z_reg) + (ZR_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
    assign ph_full = neg_reg ? -z_rnd : z_rnd;

    always_comb
    begin
        if (ph_full > ZR_W'(32767))
            ph_sat = 16'sh7FFF;
        else if (ph_full < -ZR_W'(32768))
            ph_sat = 16'sh8000;
        else
            ph_sat = PHASE_BITS'(ph_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else if (cmd.clear)
            mask_reg <= '0;
        else if (cmd.mark_zero)
            mask_reg[cmd.chan] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_zero)
            phase_reg[cmd.chan] <= '0;
        else if (cmd.store_phase)
            phase_reg[cmd.chan] <= ph_sat;
    end

    assign stat.empty      = (pair_count_reg == '0);
    assign stat.zero_sum   = (sum_i_reg[cmd.chan] == '0) && (sum_q_reg[cmd.chan] == '0);
    assign stat.need_shift = (x_reg[MAG_BITS-1:ANG_BITS] != '0)
                             || (ay_reg[MAG_BITS-1:ANG_BITS] != '0);

    assign status_now = stat.empty ? STATUS_EMPTY
                        : (mask_reg != '0) ? STATUS_ZERO_SUM : STATUS_OK;

    // The finished word is parked here so that the next set can be gathered.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.phase1        <= phase_reg[0];
            out_reg.phase2        <= phase_reg[1];
            out_reg.phase3        <= phase_reg[2];
            out_reg.status        <= status_now;
            out_reg.zero_sum_mask <= mask_reg;
        end
    end

    assign out_data = out_reg;

endmodule

>>> rtl/sdpe_ctrl.sv
module sdpe_ctrl #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  sdpe_pkg::stat_t stat,
    output sdpe_pkg::cmd_t  cmd
);
    import sdpe_pkg::*;

    localparam int         N_STEPS   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam logic [4:0] LAST_STEP = 5'(N_STEPS - 1);

    state_t     state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic [4:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            chan_reg      <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chan_reg      <= chan_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        logic advance;
        advance        = 1'b0;
        state_next     = state_reg;
        chan_next      = chan_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = 1'b1;
        cmd            = '0;
        cmd.mul_op     = MUL_NONE;
        cmd.chan       = chan_reg;
        cmd.step       = step_reg;
        unique case (state_reg)
            ST_ACC:
            begin
                in_stall   = 1'b0;
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                begin
                    chan_next  = '0;
                    state_next = ST_CHAN;
                end
            end
            ST_CHAN:
            begin
                if (stat.empty)
                begin
                    cmd.store_zero = 1'b1;
                    advance        = 1'b1;
                end
                else if (stat.zero_sum)
                begin
                    cmd.store_zero = 1'b1;
                    cmd.mark_zero  = 1'b1;
                    advance        = 1'b1;
                end
                else
                begin
                    cmd.mul_op = MUL_SI_SI;
                    state_next = ST_M1;
                end
            end
            ST_M1:
            begin
                cmd.x_load = 1'b1;
                cmd.mul_op = MUL_SQ_SQ;
                state_next = ST_M2;
            end
            ST_M2:
            begin
                cmd.x_add  = 1'b1;
                cmd.mul_op = MUL_DI_SQ;
                state_next = ST_M3;
            end
            ST_M3:
            begin
                cmd.y_load = 1'b1;
                cmd.mul_op = MUL_DQ_SI;
                state_next = ST_M4;
            end
            ST_M4:
            begin
                cmd.y_sub  = 1'b1;
                state_next = ST_ABS;
            end
            ST_ABS:
            begin
                cmd.abs_load = 1'b1;
                state_next   = ST_NORM;
            end
            ST_NORM:
            begin
                if (stat.need_shift)
                    cmd.norm = 1'b1;
                else
                begin
                    cmd.cordic_init = 1'b1;
                    step_next       = '0;
                    state_next      = ST_CORDIC;
                end
            end
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_ROUND;
                else
                    step_next = step_reg + 5'd1;
            end
            ST_ROUND:
            begin
                cmd.store_phase = 1'b1;
                advance         = 1'b1;
            end
            ST_OUT:
            begin
                // Hand over once the output register is free or being emptied.
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.clear      = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
        if (advance)
        begin
            if (chan_reg == LAST_CHAN)
                state_next = ST_OUT;
            else
            begin
                chan_next  = chan_reg + 2'd1;
                state_next = ST_CHAN;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ACC) |-> (in_stall && !cmd.acc_en))
        else $error("word taken while computing");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result word dropped");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result word overwritten before it was taken");
    a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (chan_reg != 2'd3))
        else $error("channel index out of range");
    a_cordic_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cordic_init |-> !stat.need_shift)
        else $error("CORDIC started on an unscaled vector");
`endif

endmodule

>>> rtl/sum_diff_phase_estimator.sv
// Sum/difference monopulse phase estimator. One word carrying I/Q samples of a
// reference and three further channels is taken every clock while a set is
// being gathered; a word with last set closes the set and the block then stalls
// its input while it works out the three phases one channel at a time on a
// single shared 30x30 multiplier and an iterative CORDIC. A channel whose set is
// empty or whose sum is zero gets a zero phase at once; otherwise the block forms
// the products, scales the vector one bit per cycle until it fits, runs the
// CORDIC rotations and rounds. A final state moves the result word into an output
// register, and the next set is taken from the cycle after. That hand-over waits
// only while a previous result is still held there and stalled.
module sum_diff_phase_estimator #(
    parameter int MAX_PAIRS       = 65536,
    parameter int PHASE_FRAC_BITS = 13,
    parameter int CORDIC_STEPS    = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  sdpe_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_stall,
    output sdpe_pkg::out_t out_data
);
    import sdpe_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    sdpe_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (in_data.last),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    sdpe_datapath #(
        .MAX_PAIRS      (MAX_PAIRS),
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .stat    (stat),
        .out_data(out_data)
    );

endmodule
